FILE: rtl/core/arith_expression_tokenizer_top_assert.svh
// assertion macros shared by the tokenizer rtl
`ifndef ARITH_EXPRESSION_TOKENIZER_TOP_ASSERT_SVH
`define ARITH_EXPRESSION_TOKENIZER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define AET_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aet assertion failed");

// next-cycle implication, disabled during reset
`define AET_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aet assertion failed");

`endif

FILE: rtl/core/aet_pkg.sv
// shared types, constants and decode functions of the expression tokenizer
package aet_pkg;

  localparam int ACC_W          = 63;
  localparam int TOK_POS_W      = 16;
  localparam int POS_BITS_DEF   = 16;
  localparam int OUT_TDATA_W    = 80;
  // must stay a power of two, pointers wrap naturally
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [3:0] {
    KIND_NUMBER  = 4'd0,
    KIND_PLUS    = 4'd1,
    KIND_MINUS   = 4'd2,
    KIND_MUL     = 4'd3,
    KIND_DIV     = 4'd4,
    KIND_LPAREN  = 4'd5,
    KIND_RPAREN  = 4'd6,
    KIND_EOF     = 4'd7,
    KIND_INVALID = 4'd8
  } kind_t;

  // all tokens caused by one input item
  typedef struct packed {
    logic                 has_num;
    logic                 num_bad;
    logic [ACC_W-1:0]     num_value;
    logic [TOK_POS_W-1:0] num_pos;
    logic                 has_tok;
    kind_t                tok_kind;
    logic [TOK_POS_W-1:0] tok_pos;
  } bundle_t;

  typedef struct packed {
    logic valid;
    bundle_t data;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic kind_t op_kind(input logic [7:0] c);
    kind_t k;
    unique case (c)
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_MUL;
      CH_SLASH:  k = KIND_DIV;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      default:   k = KIND_INVALID;
    endcase
    return k;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

FILE: rtl/core/arith_expression_tokenizer_top.sv
// Arithmetic expression tokenizer: takes one text byte (or an end-of-text
// marker on in_tuser) per cycle and emits number, operator, eof and invalid
// tokens, each with its start position. The front end accepts one item every
// cycle while its four-entry bundle queue has room; the back end sends one
// token per cycle while out_tready is high, so an item yielding two tokens
// (a number closed by an operator, or by end of text) takes two transfers
// and the queue absorbs bursts of those. An accepted byte's first token is
// registered in the queue, then in the output register. Positions count up
// to 2^POSITION_BITS-1 and stay there; reported positions are 16 bits.
module arith_expression_tokenizer_top #(
  parameter int POSITION_BITS = aet_pkg::POS_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] text_byte
  input  logic                            in_tuser,   // [0] end_of_text
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [62:0] token_value, [78:63] token_position, [79] zero
  output logic [aet_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [3:0]                      out_tuser,  // [3:0] token_kind
  output logic                            out_tlast   // last_of_run
);
  import aet_pkg::*;

  push_t     push;
  bundle_t   head;
  q_status_t q_stat;
  logic      pop;

  aet_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .push      (push)
  );

  aet_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .stat  (q_stat)
  );

  aet_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: rtl/core/aet_front.sv
// front end: classifies bytes, accumulates digit runs and builds token bundles
`include "arith_expression_tokenizer_top_assert.svh"
module aet_front #(
  parameter int POSITION_BITS = aet_pkg::POS_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  input  logic            in_tuser,
  input  aet_pkg::q_status_t q_stat,
  output aet_pkg::push_t  push
);
  import aet_pkg::*;

  logic                     in_number_r, in_number_nxt;
  logic [ACC_W-1:0]         acc_r, acc_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [TOK_POS_W-1:0]     start_r, start_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;

  logic                     accept;
  logic                     is_digit;
  logic [3:0]               digit;
  logic [ACC_W-1:0]         acc_base;
  logic                     ovf_base;
  logic [ACC_W+3:0]         prod;
  logic [POSITION_BITS+TOK_POS_W-1:0] pos_wide;
  logic [TOK_POS_W-1:0]     pos_tok;
  logic [POSITION_BITS-1:0] pos_inc;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  assign is_digit = (in_tdata >= CH_ZERO) && (in_tdata <= CH_NINE);
  assign digit    = 4'(in_tdata - CH_ZERO);
  assign acc_base = in_number_r ? acc_r : '0;
  assign ovf_base = in_number_r && ovf_r;
  // acc*10 + digit as shift-adds, wide enough to see any overflow
  assign prod = ({4'b0, acc_base} << 3) + ({4'b0, acc_base} << 1) + (ACC_W+4)'(digit);

  assign pos_wide = {{TOK_POS_W{1'b0}}, pos_r};
  assign pos_tok  = pos_wide[TOK_POS_W-1:0];
  assign pos_inc  = (&pos_r) ? pos_r : pos_r + 1'b1;

  always_comb begin
    in_number_nxt = in_number_r;
    acc_nxt       = acc_r;
    ovf_nxt       = ovf_r;
    start_nxt     = start_r;
    pos_nxt       = pos_r;
    push          = '0;
    push.data.tok_kind = KIND_EOF;
    push.data.num_value = acc_r;
    push.data.num_bad   = ovf_r;
    push.data.num_pos   = start_r;
    push.data.tok_pos   = pos_tok;
    if (accept) begin
      if (in_tuser) begin
        push.data.has_num  = in_number_r;
        push.data.has_tok  = 1'b1;
        push.data.tok_kind = KIND_EOF;
        in_number_nxt = 1'b0;
        acc_nxt       = '0;
        ovf_nxt       = 1'b0;
        start_nxt     = '0;
        pos_nxt       = '0;
      end else if (is_digit) begin
        in_number_nxt = 1'b1;
        if (!in_number_r) begin
          start_nxt = pos_tok;
        end
        if (ovf_base || (|prod[ACC_W+3:ACC_W])) begin
          ovf_nxt = 1'b1;
          acc_nxt = acc_base;
        end else begin
          ovf_nxt = 1'b0;
          acc_nxt = prod[ACC_W-1:0];
        end
        pos_nxt = pos_inc;
      end else begin
        push.data.has_num  = in_number_r;
        push.data.has_tok  = !is_space(in_tdata);
        push.data.tok_kind = op_kind(in_tdata);
        in_number_nxt = 1'b0;
        acc_nxt       = '0;
        ovf_nxt       = 1'b0;
        start_nxt     = '0;
        pos_nxt       = pos_inc;
      end
      push.valid = push.data.has_num || push.data.has_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_number_r <= 1'b0;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      start_r     <= '0;
      pos_r       <= '0;
    end else begin
      in_number_r <= in_number_nxt;
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      start_r     <= start_nxt;
      pos_r       <= pos_nxt;
    end
  end

  `AET_ASSERT_NEXT(a_eot_clears, clk, rst_n, accept && in_tuser, !in_number_r && (pos_r == '0))
  `AET_ASSERT_NOW(a_ovf_in_run, clk, rst_n, ovf_r, in_number_r)

endmodule

FILE: rtl/core/aet_queue.sv
// short bundle queue between front and back end
`include "arith_expression_tokenizer_top_assert.svh"
module aet_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  aet_pkg::push_t     push,
  input  logic               pop,
  output aet_pkg::bundle_t   head,
  output aet_pkg::q_status_t stat
);
  import aet_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  bundle_t            entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign head       = entry_r[rd_ptr_r];
  assign stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = push.valid ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    case ({push.valid, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entry_r[wr_ptr_r] <= push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `AET_ASSERT_NOW(a_no_push_full, clk, rst_n, push.valid, !stat.full)
  `AET_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop, !stat.empty)

endmodule

FILE: rtl/core/aet_back.sv
// back end: splits bundles into single tokens and holds the output register
`include "arith_expression_tokenizer_top_assert.svh"
module aet_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  aet_pkg::bundle_t     head,
  input  aet_pkg::q_status_t   q_stat,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [aet_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [3:0]           out_tuser,
  output logic                 out_tlast
);
  import aet_pkg::*;

  logic                 valid_r, valid_nxt;
  logic                 num_done_r, num_done_nxt;
  kind_t                kind_r, kind_nxt;
  logic [ACC_W-1:0]     value_r, value_nxt;
  logic [TOK_POS_W-1:0] tpos_r, tpos_nxt;
  logic                 last_r, last_nxt;
  logic                 load;

  assign load = !valid_r || out_tready;

  always_comb begin
    valid_nxt    = valid_r;
    num_done_nxt = num_done_r;
    kind_nxt     = kind_r;
    value_nxt    = value_r;
    tpos_nxt     = tpos_r;
    last_nxt     = last_r;
    pop          = 1'b0;
    if (load) begin
      valid_nxt = !q_stat.empty;
      if (!q_stat.empty) begin
        if (head.has_num && !num_done_r) begin
          kind_nxt  = head.num_bad ? KIND_INVALID : KIND_NUMBER;
          value_nxt = head.num_bad ? '0 : head.num_value;
          tpos_nxt  = head.num_pos;
          last_nxt  = !head.has_tok;
          if (head.has_tok) begin
            num_done_nxt = 1'b1;
          end else begin
            pop = 1'b1;
          end
        end else begin
          kind_nxt     = head.tok_kind;
          value_nxt    = '0;
          tpos_nxt     = head.tok_pos;
          last_nxt     = 1'b1;
          num_done_nxt = 1'b0;
          pop          = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      num_done_r <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      num_done_r <= num_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    tpos_r  <= tpos_nxt;
    last_r  <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {1'b0, tpos_r, value_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

  `AET_ASSERT_NOW(a_split_holds_head, clk, rst_n, num_done_r, !q_stat.empty)

endmodule

FILE: dv/arith_expression_tokenizer_top_tb.sv
// self-checking testbench for the arithmetic expression tokenizer
`timescale 1ns / 1ps

module arith_expression_tokenizer_top_tb;
  import aet_pkg::*;

  localparam int POS_BITS = POS_BITS_DEF;
  localparam logic [63:0] VALUE_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int PREDICTED = -1;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 32;
  localparam int PHASE_ITEMS = 280;

  typedef struct {
    kind_t                kind;
    logic [ACC_W-1:0]     value;
    logic [TOK_POS_W-1:0] pos;
    logic                 is_last;
  } token_t;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
    int         n_fixed;
    token_t     fixed;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = 8'h00;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [3:0]             out_tuser;
  logic                   out_tlast;

  // predictor state
  logic                run_active = 1'b0;
  logic [ACC_W-1:0]    run_value = '0;
  logic                run_ovf = 1'b0;
  logic [POS_BITS-1:0] run_start = '0;
  logic [POS_BITS-1:0] text_pos = '0;

  token_t   step_tokens[$];
  token_t   pending_tokens[$];
  dir_row_t dir_rows[$];
  token_t   none_tok;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int tokens_seen = 0;
  int overflow_runs = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  logic [7:0] op_chars[6] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAREN, CH_RPAREN};
  logic [7:0] blank_chars[6] = '{CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR, CH_SPACE};

  arith_expression_tokenizer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic token_t build_token(input kind_t k, input logic [ACC_W-1:0] v,
                                         input logic [TOK_POS_W-1:0] p, input logic l);
    token_t t;
    t.kind = k;
    t.value = v;
    t.pos = p;
    t.is_last = l;
    return t;
  endfunction

  function automatic logic is_blank(input logic [7:0] ch);
    return (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

  function automatic kind_t operator_kind(input logic [7:0] ch);
    case (ch)
      CH_PLUS:   return KIND_PLUS;
      CH_MINUS:  return KIND_MINUS;
      CH_STAR:   return KIND_MUL;
      CH_SLASH:  return KIND_DIV;
      CH_LPAREN: return KIND_LPAREN;
      CH_RPAREN: return KIND_RPAREN;
      default:   return KIND_INVALID;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // pending digit run becomes a number token, or invalid if it overflowed
  task automatic close_run(input logic mark_last);
    if (run_ovf) begin
      step_tokens.push_back(build_token(KIND_INVALID, '0, TOK_POS_W'(run_start), mark_last));
      overflow_runs++;
    end else begin
      step_tokens.push_back(build_token(KIND_NUMBER, run_value, TOK_POS_W'(run_start),
                                        mark_last));
    end
    run_active = 1'b0;
    run_value = '0;
    run_ovf = 1'b0;
    run_start = '0;
  endtask

  task automatic tokenize_item(input logic [7:0] ch, input logic eot);
    logic [63:0] digit;
    step_tokens.delete();
    if (eot) begin
      if (run_active) close_run(1'b0);
      step_tokens.push_back(build_token(KIND_EOF, '0, TOK_POS_W'(text_pos), 1'b1));
      text_pos = '0;
    end else begin
      if (is_digit(ch)) begin
        digit = 64'(ch - CH_ZERO);
        if (!run_active) begin
          run_active = 1'b1;
          run_value = '0;
          run_ovf = 1'b0;
          run_start = text_pos;
        end
        if (!run_ovf) begin
          if ({1'b0, run_value} > (VALUE_LIMIT - digit) / 64'd10)
            run_ovf = 1'b1;
          else
            run_value = ACC_W'({1'b0, run_value} * 64'd10 + digit);
        end
      end else if (is_blank(ch)) begin
        if (run_active) close_run(1'b1);
      end else begin
        if (run_active) close_run(1'b0);
        step_tokens.push_back(build_token(operator_kind(ch), '0, TOK_POS_W'(text_pos), 1'b1));
      end
      // position sticks at its top value on long text
      if (text_pos != '1) text_pos = text_pos + 1'b1;
    end
  endtask

  // expectations are queued when valid goes up; the item is never withdrawn
  task automatic send_item(input logic [7:0] ch, input logic eot, input int n_fixed,
                           input token_t fixed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    tokenize_item(ch, eot);
    if (n_fixed == PREDICTED) begin
      foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
    end else if (n_fixed == 1) begin
      pending_tokens.push_back(fixed);
    end
    in_tvalid <= 1'b1;
    in_tdata <= ch;
    in_tuser <= eot;
    items_sent++;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] ch, input logic eot);
    send_item(ch, eot, PREDICTED, none_tok);
  endtask

  task automatic add_row(input logic [7:0] ch, input logic eot, input int n_fixed,
                         input token_t t);
    dir_row_t r;
    r.ch = ch;
    r.eot = eot;
    r.n_fixed = n_fixed;
    r.fixed = t;
    dir_rows.push_back(r);
  endtask

  // one lexical piece: mostly well-formed tokens, some broken bytes and noise
  task automatic send_random_piece();
    int pick;
    int len;
    string near_max;
    logic [7:0] ch;
    near_max = "922337203685477580";
    pick = $urandom_range(99);
    if (pick < 35) begin
      len = $urandom_range(99);
      if (len < 5) begin
        // right at the overflow boundary, sometimes one digit beyond
        for (int i = 0; i < near_max.len(); i++) send_byte(near_max[i], 1'b0);
        send_byte(CH_ZERO + 8'($urandom_range(9)), 1'b0);
        if ($urandom_range(3) == 0) send_byte(CH_ZERO + 8'($urandom_range(9)), 1'b0);
      end else begin
        if (len < 15) len = $urandom_range(22, 19);
        else if (len < 30) len = $urandom_range(18, 5);
        else len = $urandom_range(4, 1);
        for (int i = 0; i < len; i++) send_byte(CH_ZERO + 8'($urandom_range(9)), 1'b0);
      end
    end else if (pick < 65) begin
      send_byte(op_chars[$urandom_range(5)], 1'b0);
    end else if (pick < 80) begin
      len = $urandom_range(3, 1);
      for (int i = 0; i < len; i++) send_byte(blank_chars[$urandom_range(5)], 1'b0);
    end else if (pick < 86) begin
      do ch = 8'($urandom_range(255));
      while (is_digit(ch) || is_blank(ch) || operator_kind(ch) != KIND_INVALID);
      send_byte(ch, 1'b0);
    end else if (pick < 90) begin
      send_byte(8'($urandom_range(255)), 1'b1);
    end else begin
      send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
    end
  endtask

  always @(posedge clk) begin : token_check
    token_t want;
    if (rst_n && out_tvalid && out_tready) begin
      tokens_seen++;
      if (pending_tokens.size() == 0) begin
        report_mismatch($sformatf("token with none expected: kind %0d pos %0d",
                                  out_tuser, out_tdata[ACC_W +: TOK_POS_W]));
      end else begin
        want = pending_tokens.pop_front();
        if (out_tuser !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %s", out_tuser, want.kind.name()));
        if (out_tdata[ACC_W-1:0] !== want.value)
          report_mismatch($sformatf("value %0d, expected %0d", out_tdata[ACC_W-1:0],
                                    want.value));
        if (out_tdata[ACC_W +: TOK_POS_W] !== want.pos)
          report_mismatch($sformatf("position %0d, expected %0d",
                                    out_tdata[ACC_W +: TOK_POS_W], want.pos));
        if (out_tdata[OUT_TDATA_W-1:ACC_W+TOK_POS_W] !== '0)
          report_mismatch("tdata pad bits not zero");
        if (out_tlast !== want.is_last)
          report_mismatch($sformatf("tlast %b, expected %b", out_tlast, want.is_last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles, %0d tokens outstanding", $time,
               QUIET_LIMIT, pending_tokens.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int send_pct[4];
    int recv_pct[4];
    int phase_start;
    send_pct = '{0, 52, 0, 22};
    recv_pct = '{0, 0, 52, 22};
    none_tok = build_token(KIND_NUMBER, '0, '0, 1'b0);

    // directed rows; positions equal row numbers until the first end of text
    add_row(CH_PLUS,      1'b0, 1, build_token(KIND_PLUS, '0, 16'd0, 1'b1));
    add_row(CH_MINUS,     1'b0, 1, build_token(KIND_MINUS, '0, 16'd1, 1'b1));
    add_row(CH_STAR,      1'b0, 1, build_token(KIND_MUL, '0, 16'd2, 1'b1));
    add_row(CH_SLASH,     1'b0, 1, build_token(KIND_DIV, '0, 16'd3, 1'b1));
    add_row(CH_LPAREN,    1'b0, 1, build_token(KIND_LPAREN, '0, 16'd4, 1'b1));
    add_row(CH_RPAREN,    1'b0, 1, build_token(KIND_RPAREN, '0, 16'd5, 1'b1));
    add_row(8'h00,        1'b0, 1, build_token(KIND_INVALID, '0, 16'd6, 1'b1));
    add_row(8'hFF,        1'b0, 1, build_token(KIND_INVALID, '0, 16'd7, 1'b1));
    add_row(CH_SPACE,     1'b0, 0, none_tok);
    add_row(CH_ZERO,      1'b0, 0, none_tok);
    // blank closing a run gives only the number, marked last
    add_row(CH_TAB,       1'b0, 1, build_token(KIND_NUMBER, '0, 16'd9, 1'b1));
    add_row(CH_CR,        1'b0, 0, none_tok);
    add_row(8'h0A,        1'b0, 0, none_tok);
    add_row(8'h0B,        1'b0, 0, none_tok);
    add_row(8'h0C,        1'b0, 0, none_tok);
    add_row(CH_ZERO + 8'd4, 1'b0, 0, none_tok);
    add_row(CH_ZERO + 8'd2, 1'b0, 0, none_tok);
    add_row(CH_PLUS,      1'b0, PREDICTED, none_tok);
    add_row(8'h08,        1'b0, 1, build_token(KIND_INVALID, '0, 16'd18, 1'b1));
    add_row(8'h0E,        1'b0, 1, build_token(KIND_INVALID, '0, 16'd19, 1'b1));
    add_row(CH_ZERO + 8'd7, 1'b0, 0, none_tok);
    add_row(8'hA5,        1'b1, PREDICTED, none_tok);
    add_row(8'h00,        1'b1, 1, build_token(KIND_EOF, '0, 16'd0, 1'b1));
    add_row(CH_SLASH,     1'b0, 1, build_token(KIND_DIV, '0, 16'd0, 1'b1));
    add_row(CH_NINE + 8'd1, 1'b0, 1, build_token(KIND_INVALID, '0, 16'd1, 1'b1));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].ch, dir_rows[i].eot, dir_rows[i].n_fixed,
                                    dir_rows[i].fixed);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pct[p];
      recv_stall_pct = recv_pct[p];
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_random_piece();
    end
    in_tvalid <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tokenizer run: %0d input transfers, %0d tokens checked, %0d overflowed runs",
             items_sent, tokens_seen, overflow_runs);
    $display("covered all operators, blanks, stray bytes, overflow edges and four idle mixes");
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
